[sv/dat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dat_pkg
// Shared types and constants of the dial angle tracker.
// ----------------------------------------------------------------------------
package dat_pkg;

    // Mode counter
    localparam int MODE_COUNT = 4;
    localparam int MODE_W     = 3;
    localparam logic [MODE_W-1:0] MODE_LAST = MODE_W'(MODE_COUNT - 1);
    localparam logic [MODE_W-1:0] MODE_UNBOUNDED = '0;

    // Field widths
    localparam int STRAIN_W = 25;
    localparam int THR_W    = 24;
    localparam int TIME_W   = 32;
    localparam int ANGLE_W  = 16;
    localparam int RAW_W    = 12;
    localparam int ALPHA_W  = 16;
    localparam int DEB_W    = 16;
    localparam int DEG_W    = 9;
    localparam int CFG_W    = 24;

    // Q9.7 angle circle
    localparam logic [ANGLE_W-1:0] FULL_TURN = 16'd46080;
    localparam logic [ANGLE_W-1:0] HALF_TURN = 16'd23040;

    // Encoder scaling: raw * 46080 / 4095 == raw * 1024 / 91, done as a
    // reciprocal multiply that is exact for every 12-bit raw value.
    localparam int ENC_RECIP_W = 28;
    localparam int ENC_SHIFT   = 24;
    localparam logic [ENC_RECIP_W-1:0] ENC_RECIP = 28'd188789772;

    // Register reset values
    localparam logic signed [THR_W-1:0] THR_RESET   = -24'sd300;
    localparam logic [DEB_W-1:0]        DEB_RESET   = 16'd250;
    localparam logic [ALPHA_W-1:0]      ALPHA_RESET = 16'd16384;
    localparam logic [MODE_W-1:0]       SWITCH_RESET = 3'd1;

    // Register indexes
    typedef enum logic [1:0] {
        REG_PRESS_THRESHOLD = 2'd0,
        REG_DEBOUNCE_MS     = 2'd1,
        REG_FILTER_ALPHA    = 2'd2,
        REG_SWITCH_MODE     = 2'd3
    } cfg_index_t;

    // Both candidate angles, already reduced to one turn
    typedef struct packed {
        logic [ANGLE_W-1:0] enc_angle;
        logic [ANGLE_W-1:0] fb_angle;
    } angle_pair_t;

endpackage

[sv/dat_angle_conv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dat_angle_conv
// Scale the raw encoder reading to Q9.7 degrees and reduce both angle
// sources into one turn.
// ----------------------------------------------------------------------------
module dat_angle_conv (
    input  logic [dat_pkg::RAW_W-1:0]   sensor_raw,
    input  logic [dat_pkg::ANGLE_W-1:0] feedback_angle,
    output dat_pkg::angle_pair_t        angles
);

    localparam int PROD_W = dat_pkg::RAW_W + dat_pkg::ENC_RECIP_W;

    logic [PROD_W-1:0]           enc_prod;
    logic [dat_pkg::ANGLE_W-1:0] enc_q;

    assign enc_prod = PROD_W'(sensor_raw) * PROD_W'(dat_pkg::ENC_RECIP);
    assign enc_q    = enc_prod[dat_pkg::ENC_SHIFT +: dat_pkg::ANGLE_W];

    // full scale lands exactly on one turn
    assign angles.enc_angle = (enc_q >= dat_pkg::FULL_TURN) ?
                              enc_q - dat_pkg::FULL_TURN : enc_q;
    assign angles.fb_angle  = (feedback_angle >= dat_pkg::FULL_TURN) ?
                              feedback_angle - dat_pkg::FULL_TURN : feedback_angle;

endmodule

[sv/dial_angle_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dial_angle_tracker_unit
// Press detection, mode selection and circular low-pass filtering of the
// dial angle, one result item per tick item.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------
//  in        in_valid / in_ready    strain, button, time, feedback, encoder
//  out       out_valid / out_ready  mode_now, mode_changed, display_*
//  cfg       cfg_we                 cfg_index, cfg_data (24 bits)
//
//  One item per cycle sustained while out_ready is high. An accepted item
//  is captured in the input register, then loaded into the result register
//  when that is empty or being taken, which raises out_valid.
//  The input register already holds the scaled encoder angle; the stage
//  after it runs press logic, mode update and one filter multiply.
//  Reset (rst_n low, asynchronous) clears mode, press state, offset and
//  filter and loads the register defaults.
//  A stalled result holds the input register; in_ready falls only when
//  both stages are full and out_ready is low.
// ----------------------------------------------------------------------------
module dial_angle_tracker_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  dat_pkg::cfg_index_t                   cfg_index,
    input  logic [dat_pkg::CFG_W-1:0]             cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [dat_pkg::STRAIN_W-1:0]   strain_sample,
    input  logic                                  strain_ready,
    input  logic                                  button_event,
    input  logic [dat_pkg::TIME_W-1:0]            now_ms,
    input  logic [dat_pkg::ANGLE_W-1:0]           feedback_angle,
    input  logic                                  feedback_valid,
    input  logic [dat_pkg::RAW_W-1:0]             sensor_raw,
    input  logic                                  sensor_valid,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [dat_pkg::MODE_W-1:0]            mode_now,
    output logic                                  mode_changed,
    output logic [dat_pkg::DEG_W-1:0]             display_degrees,
    output logic                                  display_valid
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [dat_pkg::THR_W-1:0] thr_reg;
    logic [dat_pkg::DEB_W-1:0]        deb_reg;
    logic [dat_pkg::ALPHA_W-1:0]      alpha_reg;
    logic [dat_pkg::MODE_W-1:0]       switch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= dat_pkg::THR_RESET;
            deb_reg    <= dat_pkg::DEB_RESET;
            alpha_reg  <= dat_pkg::ALPHA_RESET;
            switch_reg <= dat_pkg::SWITCH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dat_pkg::REG_PRESS_THRESHOLD: thr_reg    <= $signed(cfg_data);
                dat_pkg::REG_DEBOUNCE_MS:     deb_reg    <= cfg_data[dat_pkg::DEB_W-1:0];
                dat_pkg::REG_FILTER_ALPHA:    alpha_reg  <= cfg_data[dat_pkg::ALPHA_W-1:0];
                dat_pkg::REG_SWITCH_MODE:     switch_reg <= cfg_data[dat_pkg::MODE_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s2_go;
    logic in_take;

    assign s2_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_go;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s2_go)
                s1_valid_reg <= 1'b0;

            if (s2_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture the item with both angles pre-reduced
    // ------------------------------------------------------------------
    dat_pkg::angle_pair_t in_angles;

    dat_angle_conv u_conv (
        .sensor_raw     (sensor_raw),
        .feedback_angle (feedback_angle),
        .angles         (in_angles)
    );

    logic signed [dat_pkg::STRAIN_W-1:0] strain_reg;
    logic                                strain_ready_reg;
    logic                                button_reg;
    logic [dat_pkg::TIME_W-1:0]          now_reg;
    dat_pkg::angle_pair_t                angles_reg;
    logic                                fb_ok_reg;
    logic                                sn_ok_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            strain_reg       <= strain_sample;
            strain_ready_reg <= strain_ready;
            button_reg       <= button_event;
            now_reg          <= now_ms;
            angles_reg       <= in_angles;
            fb_ok_reg        <= feedback_valid;
            sn_ok_reg        <= sensor_valid;
        end
    end

    // ------------------------------------------------------------------
    // Tracker state
    // ------------------------------------------------------------------
    logic [dat_pkg::MODE_W-1:0]  mode_reg,     mode_next;
    logic                        pressed_reg,  pressed_next;
    logic [dat_pkg::TIME_W-1:0]  last_ms_reg,  last_ms_next;
    logic [dat_pkg::ANGLE_W-1:0] offset_reg,   offset_next;
    logic [dat_pkg::ANGLE_W-1:0] filt_reg,     filt_next;

    // press detection with hysteresis and debounce
    logic signed [dat_pkg::THR_W-1:0]    thr_adj;
    logic signed [dat_pkg::THR_W-1:0]    thr_half;
    logic [dat_pkg::TIME_W-1:0]          elapsed;
    logic                                crossed;
    logic                                press;
    logic                                advance;

    // round toward zero: bias negative values by one before the shift
    assign thr_adj  = thr_reg + $signed({{(dat_pkg::THR_W-1){1'b0}}, thr_reg[dat_pkg::THR_W-1]});
    assign thr_half = thr_adj >>> 1;
    assign elapsed  = now_reg - last_ms_reg;
    assign crossed  = strain_reg < dat_pkg::STRAIN_W'(thr_reg);
    assign press    = strain_ready_reg && crossed && !pressed_reg &&
                      (elapsed > dat_pkg::TIME_W'(deb_reg));
    assign advance  = press || button_reg;

    always_comb
    begin
        pressed_next = pressed_reg;
        last_ms_next = last_ms_reg;
        if (press)
        begin
            pressed_next = 1'b1;
            last_ms_next = now_reg;
        end
        else if (strain_ready_reg && !crossed && pressed_reg &&
                 (strain_reg > dat_pkg::STRAIN_W'(thr_half)))
        begin
            pressed_next = 1'b0;
        end
    end

    // mode advance wraps at the mode count
    logic [dat_pkg::MODE_W-1:0] mode_new;

    assign mode_new = !advance ? mode_reg :
                      (mode_reg == dat_pkg::MODE_LAST) ? dat_pkg::MODE_UNBOUNDED :
                      mode_reg + dat_pkg::MODE_W'(1);
    assign mode_next = mode_new;

    // angle source follows the mode after this tick
    logic                        have_angle;
    logic [dat_pkg::ANGLE_W-1:0] angle;

    always_comb
    begin
        have_angle = 1'b1;
        angle      = angles_reg.enc_angle;
        priority if (mode_new != dat_pkg::MODE_UNBOUNDED && fb_ok_reg)
            angle = angles_reg.fb_angle;
        else if (sn_ok_reg)
            angle = angles_reg.enc_angle;
        else
            have_angle = 1'b0;
    end

    logic [dat_pkg::ANGLE_W-1:0] offset_use;
    logic [dat_pkg::ANGLE_W-1:0] filt_base;

    assign offset_use  = (advance && have_angle) ? angle : offset_reg;
    assign offset_next = offset_use;
    assign filt_base   = advance ? '0 : filt_reg;

    // ------------------------------------------------------------------
    // Filter: shortest-path delta, one multiply, single-step wraps
    // ------------------------------------------------------------------
    localparam int REL_W  = dat_pkg::ANGLE_W + 1;
    localparam int D_W    = dat_pkg::ANGLE_W;
    localparam int PROD_W = dat_pkg::ALPHA_W + 1 + D_W;
    localparam int SUM_W  = dat_pkg::ANGLE_W + 2;

    logic signed [REL_W-1:0]  rel_raw;
    logic signed [REL_W-1:0]  rel;
    logic signed [REL_W-1:0]  d_raw;
    logic signed [REL_W-1:0]  d_wide;
    logic signed [D_W-1:0]    d;
    logic signed [PROD_W-1:0] prod;
    logic signed [REL_W-1:0]  step;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_wrap;
    logic                     run_filter;

    localparam logic signed [REL_W-1:0] FULL_S = $signed({1'b0, dat_pkg::FULL_TURN});
    localparam logic signed [REL_W-1:0] HALF_S = $signed({1'b0, dat_pkg::HALF_TURN});
    localparam logic signed [SUM_W-1:0] FULL_L = $signed({2'b00, dat_pkg::FULL_TURN});

    assign rel_raw = $signed({1'b0, angle}) - $signed({1'b0, offset_use});
    assign rel     = (rel_raw < 0) ? rel_raw + FULL_S : rel_raw;
    assign d_raw   = rel - $signed({1'b0, filt_base});

    always_comb
    begin
        d_wide = d_raw;
        priority if (d_raw > HALF_S)
            d_wide = d_raw - FULL_S;
        else if (d_raw < -HALF_S)
            d_wide = d_raw + FULL_S;
        else
            d_wide = d_raw;
    end

    assign d    = d_wide[D_W-1:0];
    // arithmetic shift floors toward minus infinity
    assign prod = PROD_W'($signed({1'b0, alpha_reg})) * PROD_W'(d);
    assign step = prod[PROD_W-1 -: REL_W];
    assign sum  = $signed({2'b00, filt_base}) + SUM_W'(step);

    always_comb
    begin
        priority if (sum < 0)
            sum_wrap = sum + FULL_L;
        else if (sum >= FULL_L)
            sum_wrap = sum - FULL_L;
        else
            sum_wrap = sum;
    end

    assign run_filter = (mode_new != switch_reg) && have_angle;
    assign filt_next  = run_filter ? sum_wrap[dat_pkg::ANGLE_W-1:0] : filt_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            pressed_reg <= 1'b0;
            last_ms_reg <= '0;
            offset_reg  <= '0;
            filt_reg    <= '0;
        end
        else if (s2_go)
        begin
            mode_reg    <= mode_next;
            pressed_reg <= pressed_next;
            last_ms_reg <= last_ms_next;
            offset_reg  <= offset_next;
            filt_reg    <= filt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [dat_pkg::MODE_W-1:0] mode_out_reg;
    logic                       changed_reg;
    logic [dat_pkg::DEG_W-1:0]  degrees_reg;
    logic                       shown_reg;

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            mode_out_reg <= mode_new;
            changed_reg  <= advance;
            degrees_reg  <= run_filter ? sum_wrap[dat_pkg::ANGLE_W-1 -: dat_pkg::DEG_W] : '0;
            shown_reg    <= run_filter;
        end
    end

    assign out_valid       = out_valid_reg;
    assign mode_now        = mode_out_reg;
    assign mode_changed    = changed_reg;
    assign display_degrees = degrees_reg;
    assign display_valid   = shown_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= dat_pkg::MODE_LAST)
        else $error("mode counter left its range");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (filt_reg < dat_pkg::FULL_TURN) && (offset_reg < dat_pkg::FULL_TURN))
        else $error("filter or offset outside one turn");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !shown_reg |-> degrees_reg == '0)
        else $error("hidden display carries nonzero degrees");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        s2_go |=> out_valid_reg)
        else $error("processed item produced no result");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_go |=> s1_valid_reg)
        else $error("stalled item dropped from input stage");

endmodule
